// ----- sv/orhl_pkg.sv -----
package orhl_pkg;

   // Command codes carried in the action field.
   typedef enum logic [2:0] {
      ACT_SAVE        = 3'd0,
      ACT_CLEAR       = 3'd1,
      ACT_READ_POS    = 3'd2,
      ACT_READ_NEWEST = 3'd3,
      ACT_STATUS      = 3'd4
   } action_type;

   localparam int unsigned ACTION_BITS   = 3;
   localparam int unsigned PAYLOAD_W     = 64;
   localparam int unsigned POSITION_BITS = 5;
   localparam int unsigned SEQ_BITS      = 32;
   localparam int unsigned COUNT_BITS    = 6;
   localparam int unsigned SLOT_BITS     = 5;

   // Request item layout, lowest bit first.
   localparam int unsigned REQ_ACTION_LSB   = 0;
   localparam int unsigned REQ_PAYLOAD_LSB  = REQ_ACTION_LSB + ACTION_BITS;
   localparam int unsigned REQ_POSITION_LSB = REQ_PAYLOAD_LSB + PAYLOAD_W;
   localparam int unsigned REQ_USED_BITS    = REQ_POSITION_LSB + POSITION_BITS;
   localparam int unsigned REQ_DATA_BITS    = ((REQ_USED_BITS + 7) / 8) * 8;

   // Response item layout, lowest bit first.
   localparam int unsigned RSP_OK_LSB      = 0;
   localparam int unsigned RSP_PAYLOAD_LSB = RSP_OK_LSB + 1;
   localparam int unsigned RSP_SEQ_LSB     = RSP_PAYLOAD_LSB + PAYLOAD_W;
   localparam int unsigned RSP_COUNT_LSB   = RSP_SEQ_LSB + SEQ_BITS;
   localparam int unsigned RSP_SLOT_LSB    = RSP_COUNT_LSB + COUNT_BITS;
   localparam int unsigned RSP_EN_LSB      = RSP_SLOT_LSB + SLOT_BITS;
   localparam int unsigned RSP_USED_BITS   = RSP_EN_LSB + 1;
   localparam int unsigned RSP_DATA_BITS   = ((RSP_USED_BITS + 7) / 8) * 8;

endpackage

// ----- sv/orhl_ram.sv -----
module orhl_ram #(
   parameter int unsigned WIDTH = 96,
   parameter int unsigned DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- sv/overwrite_ring_history_log_core.sv -----
// Overwrite-oldest history log. Each save stores a payload with a running
// 32-bit sequence number (starting at 1) in a ring of DEPTH entries held in one
// synchronous RAM; once the ring is full the oldest entry is overwritten.
// Reads fetch by chronological position (0 = oldest) or the newest entry.
// Every request item gives exactly one response item. An accepted item waits
// in the pending register while the RAM's registered read completes at the
// accept edge, then loads the response register once it is free; the block
// takes one item per cycle as long as rsp_tready stays high, and the RAM read
// port is the only shared unit on that path. Log contents need no clearing
// after reset or clear: reads are bounded by the entry count. Write csr_wdata
// (store enabled) only while idle.
module overwrite_ring_history_log_core
   import orhl_pkg::*;
#(
   parameter int unsigned DEPTH        = 32,
   parameter int unsigned PAYLOAD_BITS = 64
) (
   input  logic                     clock,
   input  logic                     reset,
   // req_tdata: action[2:0], payload_in[66:3], position[71:67]
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [REQ_DATA_BITS-1:0] req_tdata,
   // rsp_tdata: ok[0], payload_out[64:1], sequence_out[96:65],
   // count_out[102:97], write_slot_out[107:103], enabled_out[108], zero above
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [RSP_DATA_BITS-1:0] rsp_tdata,
   // store enabled register
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [0:0]               csr_wdata
);

   localparam int unsigned SW    = $clog2(DEPTH);
   localparam int unsigned CW    = $clog2(DEPTH + 1);
   localparam int unsigned AW    = ((SW > POSITION_BITS) ? SW : POSITION_BITS) + 1;
   localparam int unsigned WORD  = SEQ_BITS + PAYLOAD_BITS;

   // Architectural state.
   logic                 en_ff;
   logic [CW-1:0]        cnt_ff, cnt_in;
   logic [SW-1:0]        slot_ff, slot_in;
   logic [SEQ_BITS-1:0]  seq_ff, seq_in;

   // Item waiting for RAM read data.
   logic                 pend_ff;
   logic                 pend_read_ff, pend_read_in;
   logic                 pend_ok_ff, pend_ok_in;
   logic [SEQ_BITS-1:0]  pend_seq_ff, pend_seq_in;
   logic [CW-1:0]        pend_cnt_ff;
   logic [SW-1:0]        pend_slot_ff;
   logic                 pend_en_ff;

   // Response register.
   logic                     rsp_tvalid_ff;
   logic [RSP_DATA_BITS-1:0] rsp_data_ff, rsp_data_in;

   logic                     accept, out_free, advance;
   action_type               act;
   logic [POSITION_BITS-1:0] pos;
   logic [AW-1:0]            pos_ext, cnt_ext, wrap_sum;

   logic                 wr_en, rd_en;
   logic [SW-1:0]        rd_addr;
   logic [WORD-1:0]      wr_word, rd_word;

   logic [CW+COUNT_BITS-1:0]        cnt_wide;
   logic [SW+SLOT_BITS-1:0]         slot_wide;
   logic [PAYLOAD_BITS+PAYLOAD_W-1:0] pay_wide;
   logic [PAYLOAD_W-1:0]            pay_res;
   logic [SEQ_BITS-1:0]             seq_res;

   assign csr_ready = 1'b1;

   // Advance the pending item into the response register when it is free.
   assign out_free   = !rsp_tvalid_ff || rsp_tready;
   assign advance    = pend_ff && out_free;
   assign req_tready = !pend_ff || out_free;
   assign accept     = req_tvalid && req_tready;

   assign act      = action_type'(req_tdata[REQ_ACTION_LSB +: ACTION_BITS]);
   assign pos      = req_tdata[REQ_POSITION_LSB +: POSITION_BITS];
   assign pos_ext  = AW'(pos);
   assign cnt_ext  = AW'(cnt_ff);
   // Unroll from the write slot once full; position < count keeps sum < 2*DEPTH.
   assign wrap_sum = AW'(slot_ff) + pos_ext;
   assign wr_word  = {seq_ff, req_tdata[REQ_PAYLOAD_LSB +: PAYLOAD_BITS]};

   always_comb begin
      cnt_in       = cnt_ff;
      slot_in      = slot_ff;
      seq_in       = seq_ff;
      wr_en        = 1'b0;
      rd_en        = 1'b0;
      rd_addr      = '0;
      pend_read_in = 1'b0;
      pend_ok_in   = 1'b0;
      pend_seq_in  = '0;
      unique case (act)
         ACT_SAVE: begin
            if (en_ff) begin
               wr_en       = accept;
               seq_in      = seq_ff + 1'b1;
               slot_in     = (slot_ff == SW'(DEPTH - 1)) ? '0 : slot_ff + 1'b1;
               cnt_in      = (cnt_ff == CW'(DEPTH)) ? cnt_ff : cnt_ff + 1'b1;
               pend_ok_in  = 1'b1;
               pend_seq_in = seq_ff;
            end
         end
         ACT_CLEAR: begin
            if (en_ff) begin
               cnt_in     = '0;
               slot_in    = '0;
               seq_in     = SEQ_BITS'(1);
               pend_ok_in = 1'b1;
            end
         end
         ACT_READ_POS: begin
            if (pos_ext < cnt_ext) begin
               rd_en        = accept;
               pend_read_in = 1'b1;
               pend_ok_in   = 1'b1;
               if (cnt_ff != CW'(DEPTH)) begin
                  rd_addr = pos_ext[SW-1:0];
               end else if (wrap_sum >= AW'(DEPTH)) begin
                  rd_addr = SW'(wrap_sum - AW'(DEPTH));
               end else begin
                  rd_addr = wrap_sum[SW-1:0];
               end
            end
         end
         ACT_READ_NEWEST: begin
            if (cnt_ff != '0) begin
               rd_en        = accept;
               pend_read_in = 1'b1;
               pend_ok_in   = 1'b1;
               rd_addr      = (slot_ff == '0) ? SW'(DEPTH - 1) : slot_ff - 1'b1;
            end
         end
         ACT_STATUS: begin
            pend_ok_in = 1'b1;
         end
         default: begin
            pend_ok_in = 1'b0;
         end
      endcase
   end

   // A save writes the RAM at the accept edge; any later read samples the
   // array at a later edge, so read-after-write needs no bypass.
   orhl_ram #(
      .WIDTH (WORD),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (slot_ff),
      .wr_data (wr_word),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_word)
   );

   // Build the response from the pending item and the RAM read data.
   always_comb begin
      cnt_wide  = {{COUNT_BITS{1'b0}}, pend_cnt_ff};
      slot_wide = {{SLOT_BITS{1'b0}}, pend_slot_ff};
      pay_wide  = {{PAYLOAD_W{1'b0}}, rd_word[PAYLOAD_BITS-1:0]};
      if (pend_read_ff) begin
         pay_res = pay_wide[PAYLOAD_W-1:0];
         seq_res = rd_word[PAYLOAD_BITS +: SEQ_BITS];
      end else begin
         pay_res = '0;
         seq_res = pend_seq_ff;
      end
      rsp_data_in = '0;
      rsp_data_in[RSP_OK_LSB]                    = pend_ok_ff;
      rsp_data_in[RSP_PAYLOAD_LSB +: PAYLOAD_W]  = pay_res;
      rsp_data_in[RSP_SEQ_LSB +: SEQ_BITS]       = seq_res;
      rsp_data_in[RSP_COUNT_LSB +: COUNT_BITS]   = cnt_wide[COUNT_BITS-1:0];
      rsp_data_in[RSP_SLOT_LSB +: SLOT_BITS]     = slot_wide[SLOT_BITS-1:0];
      rsp_data_in[RSP_EN_LSB]                    = pend_en_ff;
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         en_ff         <= 1'b1;
         cnt_ff        <= '0;
         slot_ff       <= '0;
         seq_ff        <= SEQ_BITS'(1);
         pend_ff       <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            en_ff <= csr_wdata[0];
         end
         if (accept) begin
            cnt_ff  <= cnt_in;
            slot_ff <= slot_in;
            seq_ff  <= seq_in;
            pend_ff <= 1'b1;
         end else if (advance) begin
            pend_ff <= 1'b0;
         end
         if (advance) begin
            rsp_tvalid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_tvalid_ff <= 1'b0;
         end
      end
   end

   // Payload registers: hold the pending item, capture the state after it.
   always_ff @(posedge clock) begin
      if (accept) begin
         pend_read_ff <= pend_read_in;
         pend_ok_ff   <= pend_ok_in;
         pend_seq_ff  <= pend_seq_in;
         pend_cnt_ff  <= cnt_in;
         pend_slot_ff <= slot_in;
         pend_en_ff   <= en_ff;
      end
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// ----- sv/orhl_checker.sv -----
module orhl_checker
   import orhl_pkg::*;
#(
   parameter int unsigned DEPTH = 32
) (
   input logic                     clock,
   input logic                     reset,
   input logic                     rsp_tvalid,
   input logic                     rsp_tready,
   input logic [RSP_DATA_BITS-1:0] rsp_tdata
);

   // Hold a stalled response.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response changed while stalled");

   // Drop any response across reset.
   a_rsp_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid right after reset");

   // An empty log never returns a payload.
   a_empty_no_payload: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (DEPTH >= 64 || rsp_tdata[RSP_COUNT_LSB +: COUNT_BITS] == '0)
      |-> (DEPTH >= 64 || rsp_tdata[RSP_PAYLOAD_LSB +: PAYLOAD_W] == '0))
      else $error("payload returned from empty log");

   // Keep the reported write slot inside the ring.
   a_slot_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (DEPTH > 32 ||
                      32'(rsp_tdata[RSP_SLOT_LSB +: SLOT_BITS]) < DEPTH))
      else $error("write slot out of range");

endmodule

bind overwrite_ring_history_log_core orhl_checker #(.DEPTH(DEPTH)) u_orhl_checker (.*);

// ----- sim/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;
   import orhl_pkg::*;

   // Ring depth of the instance under test; a power of two, so slot
   // arithmetic wraps on its own at SLOT_BITS.
   localparam int LOG_DEPTH = 32;
   // Idle cycles to wait after the last predicted response has come back.
   localparam int SETTLE_CYCLES = 6;
   // Cycle count at which the run is stopped as hung.
   localparam int CYCLE_LIMIT = 500000;
   // Cap on printed mismatch lines; mismatches past it are still counted.
   localparam int PRINT_CAP = 60;

   // Action codes outside the defined set; the block must refuse them.
   localparam logic [ACTION_BITS-1:0] ACT_UNKNOWN_FIRST = 3'd5;
   localparam logic [ACTION_BITS-1:0] ACT_UNKNOWN_LAST  = 3'd7;

   // One response item, split into its fields.
   typedef struct packed {
      logic                  ok;
      logic [PAYLOAD_W-1:0]  payload;
      logic [SEQ_BITS-1:0]   seq;
      logic [COUNT_BITS-1:0] count;
      logic [SLOT_BITS-1:0]  slot;
      logic                  enabled;
   } log_result_type;

   logic                     clock;
   logic                     reset = 1'b1;
   logic                     req_tvalid = 1'b0;
   logic                     req_tready;
   // req_tdata: action, payload_in, position (lowest bit first)
   logic [REQ_DATA_BITS-1:0] req_tdata = '0;
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   // rsp_tdata: ok, payload_out, sequence_out, count_out, write_slot_out,
   // enabled_out (lowest bit first), zero above
   logic [RSP_DATA_BITS-1:0] rsp_tdata;
   logic                     csr_valid = 1'b0;
   logic                     csr_ready;
   logic [0:0]               csr_wdata = 1'b0;

   // Predicted state of the log, advanced once per accepted request item.
   logic [PAYLOAD_W-1:0]  log_payloads [LOG_DEPTH];
   logic [SEQ_BITS-1:0]   log_sequences [LOG_DEPTH];
   logic [COUNT_BITS-1:0] log_count = '0;
   logic [SLOT_BITS-1:0]  log_write_slot = '0;
   logic [SEQ_BITS-1:0]   log_next_seq = 32'd1;
   logic                  store_enabled_model = 1'b1;

   // Responses predicted but not yet seen, oldest first.
   log_result_type pending_results[$];

   int  mismatches = 0;
   int  results_seen = 0;
   int  cycle_count = 0;
   // Idle controls for the two sides; both off for the closing phase.
   bit  feed_gaps_on = 1'b1;
   bit  rsp_stall_on = 1'b0;
   int  rsp_stall_left = 0;

   overwrite_ring_history_log_core #(
      .DEPTH        (LOG_DEPTH),
      .PAYLOAD_BITS (PAYLOAD_W)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_wdata  (csr_wdata)
   );

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   // Hard stop in case the block hangs.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("tb_top NOT OK");
         $finish;
      end
   end

   // Result side back-pressure: stall in random bursts, otherwise keep ready high.
   always @(posedge clock) begin
      if (rsp_stall_left != 0) begin
         rsp_stall_left <= rsp_stall_left - 1;
         rsp_tready <= (rsp_stall_left == 1);
      end else if (rsp_stall_on && $urandom_range(0, 9) == 0) begin
         rsp_stall_left <= $urandom_range(1, 19);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   task automatic report_mismatch(input string what, input logic [63:0] want,
                                  input logic [63:0] got);
      if (mismatches < PRINT_CAP)
         $display("result %0d: %s expected 0x%0h got 0x%0h", results_seen, what, want, got);
      mismatches++;
   endtask

   // Compare every accepted response with the oldest prediction.
   always @(posedge clock) begin
      log_result_type want;
      log_result_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.ok      = rsp_tdata[RSP_OK_LSB];
         got.payload = rsp_tdata[RSP_PAYLOAD_LSB +: PAYLOAD_W];
         got.seq     = rsp_tdata[RSP_SEQ_LSB +: SEQ_BITS];
         got.count   = rsp_tdata[RSP_COUNT_LSB +: COUNT_BITS];
         got.slot    = rsp_tdata[RSP_SLOT_LSB +: SLOT_BITS];
         got.enabled = rsp_tdata[RSP_EN_LSB];
         if (pending_results.size() == 0) begin
            report_mismatch("unexpected item", 64'd0, 64'd1);
         end else begin
            want = pending_results.pop_front();
            if (got.ok !== want.ok)
               report_mismatch("ok", want.ok, got.ok);
            if (got.payload !== want.payload)
               report_mismatch("payload_out", want.payload, got.payload);
            if (got.seq !== want.seq)
               report_mismatch("sequence_out", want.seq, got.seq);
            if (got.count !== want.count)
               report_mismatch("count_out", want.count, got.count);
            if (got.slot !== want.slot)
               report_mismatch("write_slot_out", want.slot, got.slot);
            if (got.enabled !== want.enabled)
               report_mismatch("enabled_out", want.enabled, got.enabled);
         end
         results_seen++;
      end
   end

   // Apply one command to the predicted log and return the response it gives.
   function automatic log_result_type apply_log_command(
         input logic [ACTION_BITS-1:0] act,
         input logic [PAYLOAD_W-1:0] pay,
         input logic [POSITION_BITS-1:0] pos);
      log_result_type r;
      logic [SLOT_BITS-1:0] slot;
      r = '0;
      case (act)
         ACT_SAVE: begin
            // Refused while the store is off; state stays as it is.
            if (store_enabled_model) begin
               log_payloads[log_write_slot] = pay;
               log_sequences[log_write_slot] = log_next_seq;
               r.seq = log_next_seq;
               r.ok = 1'b1;
               log_next_seq = log_next_seq + 32'd1;
               log_write_slot = log_write_slot + 5'd1;
               if (log_count < LOG_DEPTH)
                  log_count = log_count + 6'd1;
            end
         end
         ACT_CLEAR: begin
            if (store_enabled_model) begin
               log_count = '0;
               log_write_slot = '0;
               log_next_seq = 32'd1;
               r.ok = 1'b1;
            end
         end
         ACT_READ_POS: begin
            // Once the ring is full the oldest entry sits at the write slot.
            if (pos < log_count) begin
               slot = (log_count < LOG_DEPTH) ? pos : SLOT_BITS'(log_write_slot + pos);
               r.payload = log_payloads[slot];
               r.seq = log_sequences[slot];
               r.ok = 1'b1;
            end
         end
         ACT_READ_NEWEST: begin
            if (log_count != 0) begin
               slot = log_write_slot - 5'd1;
               r.payload = log_payloads[slot];
               r.seq = log_sequences[slot];
               r.ok = 1'b1;
            end
         end
         ACT_STATUS: r.ok = 1'b1;
         default: ;
      endcase
      r.count = log_count;
      r.slot = log_write_slot;
      r.enabled = store_enabled_model;
      return r;
   endfunction

   // Offer one request item, hold it until taken, then log its prediction.
   // Leave valid high on return so back-to-back items need no extra edge.
   task automatic send_command(input logic [ACTION_BITS-1:0] act,
                               input logic [PAYLOAD_W-1:0] pay,
                               input logic [POSITION_BITS-1:0] pos);
      logic [REQ_DATA_BITS-1:0] word;
      word = '0;
      word[REQ_ACTION_LSB +: ACTION_BITS] = act;
      word[REQ_PAYLOAD_LSB +: PAYLOAD_W] = pay;
      word[REQ_POSITION_LSB +: POSITION_BITS] = pos;
      if (feed_gaps_on && $urandom_range(0, 9) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= word;
      do @(posedge clock); while (!req_tready);
      pending_results.push_back(apply_log_command(act, pay, pos));
   endtask

   // Drop valid and wait until every predicted response has come back.
   task automatic settle_log();
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Write the store-enabled register; only done with the block idle.
   task automatic write_store_enabled(input logic value);
      settle_log();
      csr_valid <= 1'b1;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      store_enabled_model = value;
   endtask

   function automatic logic [PAYLOAD_W-1:0] pick_payload();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return '1;
         default: return {$urandom, $urandom};
      endcase
   endfunction

   // Extremes, every action and the refusal cases on a nearly empty log.
   task automatic test_basic_commands();
      write_store_enabled(1'b1);
      send_command(ACT_STATUS, '0, '0);
      send_command(ACT_READ_NEWEST, '0, '0);      // empty log
      send_command(ACT_READ_POS, '1, 5'd0);       // empty log
      send_command(ACT_SAVE, '0, '1);
      send_command(ACT_SAVE, '1, '0);
      send_command(ACT_READ_POS, '0, 5'd0);
      send_command(ACT_READ_POS, '0, 5'd1);
      send_command(ACT_READ_POS, '0, 5'd2);       // equal to the count
      send_command(ACT_READ_POS, '0, 5'd31);
      send_command(ACT_READ_NEWEST, '1, '1);
      for (int c = ACT_UNKNOWN_FIRST; c <= ACT_UNKNOWN_LAST; c++)
         send_command(ACTION_BITS'(c), '1, '1);
      send_command(ACT_CLEAR, '1, '1);
      send_command(ACT_READ_NEWEST, '0, '0);
      send_command(ACT_SAVE, 64'h0123_4567_89ab_cdef, '0);  // numbering restarts
      send_command(ACT_STATUS, '1, '1);
   endtask

   // Store switched off: save and clear are refused, reads still work.
   task automatic test_store_disabled();
      write_store_enabled(1'b0);
      send_command(ACT_SAVE, '1, '0);
      send_command(ACT_CLEAR, '0, '0);
      send_command(ACT_READ_POS, '0, 5'd0);
      send_command(ACT_READ_NEWEST, '0, '0);
      send_command(ACT_STATUS, '0, '0);
      write_store_enabled(1'b1);
   endtask

   // Fill the ring, often past its depth so the oldest entries get
   // overwritten, then sweep every position and the newest entry.
   task automatic test_ring_sweep(input int rounds);
      int n;
      repeat (rounds) begin
         send_command(ACT_CLEAR, pick_payload(), 5'($urandom));
         n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 31) : $urandom_range(32, 80);
         repeat (n) send_command(ACT_SAVE, pick_payload(), 5'($urandom));
         for (int p = 0; p < LOG_DEPTH; p++)
            send_command(ACT_READ_POS, pick_payload(), 5'(p));
         send_command(ACT_READ_NEWEST, pick_payload(), 5'($urandom));
         send_command(ACT_STATUS, pick_payload(), 5'($urandom));
      end
   endtask

   // Mixed traffic, weighted toward saves and reads so the ring fills and
   // wraps; unknown actions are rare, clears rarer still.
   task automatic test_mixed_traffic(input int items);
      int w;
      logic [ACTION_BITS-1:0] act;
      logic [POSITION_BITS-1:0] pos;
      repeat (items) begin
         w = $urandom_range(0, 199);
         pos = 5'($urandom);
         if (w < 2)
            act = ACT_CLEAR;
         else if (w < 6)
            act = ACTION_BITS'($urandom_range(ACT_UNKNOWN_FIRST, ACT_UNKNOWN_LAST));
         else if (w < 96)
            act = ACT_SAVE;
         else if (w < 160) begin
            act = ACT_READ_POS;
            // Mostly aim inside the log, sometimes anywhere.
            if (log_count != 0 && $urandom_range(0, 3) != 0)
               pos = 5'($urandom_range(0, log_count - 1));
         end else if (w < 190)
            act = ACT_READ_NEWEST;
         else
            act = ACT_STATUS;
         send_command(act, pick_payload(), pos);
      end
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_basic_commands();
      rsp_stall_on <= 1'b1;
      test_store_disabled();
      test_ring_sweep(6);
      test_mixed_traffic(450);
      write_store_enabled(1'b0);
      test_mixed_traffic(150);
      write_store_enabled(1'b1);

      // Closing phase: full rate on both sides.
      feed_gaps_on = 1'b0;
      rsp_stall_on <= 1'b0;
      test_mixed_traffic(450);
      settle_log();

      if (mismatches == 0)
         $display("tb_top OK");
      else
         $display("tb_top NOT OK");
      $finish;
   end

endmodule

// ----- overwrite_ring_history_log_core.f -----
sv/orhl_pkg.sv
sv/orhl_ram.sv
sv/overwrite_ring_history_log_core.sv
sv/orhl_checker.sv
sim/tb_top.sv
